[sv/fez_pkg.sv]
package fez_pkg;

  localparam int IDX_W     = 16;
  localparam int SAMPLE_W  = 16;
  localparam int MAG_W     = SAMPLE_W + 1;
  localparam int SQ_W      = 47;
  localparam int CC_W      = 16;
  localparam int WM_W      = 45;
  localparam int ENERGY_W  = 31;
  localparam int RATE_W    = 16;
  localparam int DVD_W     = SQ_W;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);
  localparam int CFG_W     = 16;
  localparam int OUT_W     = 96;

  localparam logic [CFG_W-1:0] FRAME_LENGTH_RST = 16'd16000;

  localparam logic REG_FRAME_LENGTH  = 1'b0;
  localparam logic REG_LISTEN_ENABLE = 1'b1;

  typedef struct packed {
    logic [SQ_W-1:0]  sq;
    logic [CC_W-1:0]  cc;
    logic [WM_W-1:0]  wm;
    logic [IDX_W-1:0] n;
  } frame_sums_t;

  typedef struct packed {
    logic load;
    logic step;
    logic swap;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic out_free;
  } ctrl_sts_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV_E = 5'b00010,
    ST_SWAP  = 5'b00100,
    ST_DIV_Z = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

endpackage

[sv/fez_accum.sv]
module fez_accum (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [fez_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fez_pkg::SAMPLE_W-1:0]      in_tdata,
  input  logic                              busy,
  output fez_pkg::frame_sums_t              sums,
  output logic                              frame_done
);
  import fez_pkg::*;

  logic [CFG_W-1:0] frame_len_r;
  logic             listen_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic [CC_W-1:0]  cc_r, cc_nxt;
  logic [WM_W-1:0]  wm_r, wm_nxt;
  logic             prev_neg_r;

  logic [IDX_W-1:0]   eff_len;
  logic [IDX_W:0]     n_wide;
  logic               last;
  logic               acc;
  logic               neg;
  logic [MAG_W-1:0]   mag;
  logic [2*MAG_W-1:0] sq_prod;
  logic [MAG_W+IDX_W-1:0] wm_prod;

  // frame_length is as wide as the sample counter, so no cap is needed
  assign eff_len = (frame_len_r == '0) ? IDX_W'(1) : IDX_W'(frame_len_r);
  assign n_wide  = {1'b0, idx_r} + (IDX_W+1)'(1);
  assign last    = n_wide >= {1'b0, eff_len};

  // the closing item of a frame waits until the divider is free
  assign in_tready  = !listen_r || !last || !busy;
  assign acc        = in_tvalid && in_tready && listen_r;
  assign frame_done = acc && last;

  assign neg     = in_tdata[SAMPLE_W-1];
  assign mag     = neg ? (MAG_W'(1) << (SAMPLE_W)) - {1'b0, in_tdata} : {1'b0, in_tdata};
  assign sq_prod = mag * mag;
  assign wm_prod = mag * idx_r;

  always_comb begin
    sq_nxt  = sq_r + SQ_W'(sq_prod);
    cc_nxt  = cc_r;
    wm_nxt  = wm_r;
    idx_nxt = idx_r;
    if (idx_r != '0 && neg != prev_neg_r) begin
      cc_nxt = cc_r + CC_W'(1);
    end
    if (idx_r < (eff_len >> 1)) begin
      wm_nxt = wm_r + WM_W'(wm_prod);
    end
    idx_nxt = n_wide[IDX_W-1:0];
  end

  assign sums.sq = sq_nxt;
  assign sums.cc = cc_nxt;
  assign sums.wm = wm_nxt;
  assign sums.n  = idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_len_r <= FRAME_LENGTH_RST;
      listen_r    <= 1'b0;
      idx_r       <= '0;
      sq_r        <= '0;
      cc_r        <= '0;
      wm_r        <= '0;
      prev_neg_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_FRAME_LENGTH: frame_len_r <= cfg_wdata;
        REG_LISTEN_ENABLE: begin
          listen_r <= cfg_wdata[0];
          if (cfg_wdata[0]) begin
            idx_r      <= '0;
            sq_r       <= '0;
            cc_r       <= '0;
            wm_r       <= '0;
            prev_neg_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end else if (acc) begin
      if (last) begin
        idx_r      <= '0;
        sq_r       <= '0;
        cc_r       <= '0;
        wm_r       <= '0;
        prev_neg_r <= 1'b0;
      end else begin
        idx_r      <= idx_nxt;
        sq_r       <= sq_nxt;
        cc_r       <= cc_nxt;
        wm_r       <= wm_nxt;
        prev_neg_r <= neg;
      end
    end
  end

endmodule

[sv/fez_div.sv]
module fez_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fez_pkg::ctrl_cmd_t           cmd,
  input  fez_pkg::frame_sums_t         sums,
  output logic                         out_free,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [fez_pkg::OUT_W-1:0]    out_tdata
);
  import fez_pkg::*;

  logic [DVD_W-1:0]    dvd_r;
  logic [IDX_W-1:0]    rem_r;
  logic [IDX_W-1:0]    n_r;
  logic [CC_W-1:0]     cc_r;
  logic [WM_W-1:0]     wm_r;
  logic [ENERGY_W-1:0] energy_r;

  logic                out_valid_r;
  logic [ENERGY_W-1:0] out_energy_r;
  logic [RATE_W-1:0]   out_rate_r;
  logic [WM_W-1:0]     out_wm_r;

  logic [IDX_W:0]      rem_sh;
  logic [IDX_W:0]      rem_sub;
  logic                qbit;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, n_r};
  assign qbit    = rem_sh >= {1'b0, n_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd_r <= sums.sq;
      rem_r <= '0;
      n_r   <= sums.n;
      cc_r  <= sums.cc;
      wm_r  <= sums.wm;
    end else if (cmd.swap) begin
      energy_r <= dvd_r[ENERGY_W-1:0];
      dvd_r    <= DVD_W'({cc_r, {RATE_W{1'b0}}});
      rem_r    <= '0;
    end else if (cmd.step) begin
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
      rem_r <= qbit ? rem_sub[IDX_W-1:0] : rem_sh[IDX_W-1:0];
    end
  end

  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_energy_r <= energy_r;
      out_rate_r   <= dvd_r[RATE_W-1:0];
      out_wm_r     <= wm_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_wm_r, out_rate_r, out_energy_r});

endmodule

[sv/fez_ctrl.sv]
module fez_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  fez_pkg::ctrl_sts_t sts,
  output fez_pkg::ctrl_cmd_t cmd,
  output logic               busy
);
  import fez_pkg::*;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               cnt_last;

  assign cnt_last = cnt_r == CNT_W'(DIV_STEPS - 1);
  assign busy     = state_r != ST_IDLE;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.load     = 1'b0;
    cmd.step     = 1'b0;
    cmd.swap     = 1'b0;
    cmd.out_load = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (sts.frame_done) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_DIV_E;
        end
      end
      ST_DIV_E: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_last) begin
          state_nxt = ST_SWAP;
        end
      end
      ST_SWAP: begin
        cmd.swap  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV_Z;
      end
      ST_DIV_Z: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_last) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[sv/frame_energy_zcr_extractor.sv]
// Short-time energy and zero-crossing feature extractor. While listen_enable
// is set, signed 16-bit samples are taken one per clock, save for the stall on
// a frame's closing item below, and cut into frames of frame_length samples
// (0 is treated as 1); writing listen_enable = 1 drops any partial frame, and
// items taken while disabled are discarded. Each full frame yields one result:
// floor(sum of squares / n), floor(crossings * 2^16 / n) and the
// index-weighted magnitude sum over the first floor(length/2) samples. The two
// quotients come from one shared restoring divider, one bit per cycle: 47
// steps for the energy, a swap state and 47 steps for the rate. Meanwhile the
// next frame keeps filling at one item per cycle, but its closing item is held
// off (in_tready low) until the divider has finished the previous frame and
// its result has moved into the output register, so short frames are paced by
// the divider rather than by the input.
module frame_energy_zcr_extractor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic                           cfg_addr,
  input  logic [fez_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [15:0] sample
  input  logic [fez_pkg::SAMPLE_W-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [30:0] mean_energy, [46:31] crossing_rate, [91:47] weighted_magnitude
  output logic [fez_pkg::OUT_W-1:0]      out_tdata
);
  import fez_pkg::*;

  frame_sums_t sums;
  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;
  logic        busy;
  logic        frame_done;
  logic        out_free;

  assign sts.frame_done = frame_done;
  assign sts.out_free   = out_free;

  fez_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .busy       (busy),
    .sums       (sums),
    .frame_done (frame_done)
  );

  fez_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fez_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sums       (sums),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

[dv/tb.sv]
module tb;
  import fez_pkg::*;

  localparam int unsigned DIRECTED_ROWS  = 25;
  localparam int unsigned RANDOM_ITEMS   = 320;
  localparam int unsigned LATENCY_WAIT   = 128;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [ENERGY_W-1:0] mean_energy;
    logic [RATE_W-1:0]   crossing_rate;
    logic [WM_W-1:0]     weighted_magnitude;
  } features_t;

  typedef enum logic [2:0] {
    OP_SET_LENGTH,
    OP_SET_LISTEN,
    OP_CONST,
    OP_ALTERNATE,
    OP_RANDOM
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [15:0]         value;
    logic [16:0]         count;
    logic                typed;
    features_t           known;
  } step_t;

  localparam features_t NO_RESULT = '0;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_we     = 1'b0;
  logic                cfg_addr   = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata  = '0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [SAMPLE_W-1:0] in_tdata   = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;

  // predictor copy of the registers and the frame accumulators
  logic [15:0]         frame_len  = FRAME_LENGTH_RST;
  logic                listen_on  = 1'b0;
  logic [IDX_W-1:0]    acc_index  = '0;
  logic [SQ_W-1:0]     acc_square = '0;
  logic [CC_W-1:0]     acc_cross  = '0;
  logic [WM_W-1:0]     acc_mag    = '0;
  logic                acc_prev_neg = 1'b0;

  features_t           feature_q[$];
  bit                  typed_on = 1'b0;
  features_t           typed_result = NO_RESULT;
  bit                  jitter_on = 1'b1;
  int unsigned         mismatches = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         stall_left = 0;

  frame_energy_zcr_extractor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_frame();
    acc_index    = '0;
    acc_square   = '0;
    acc_cross    = '0;
    acc_mag      = '0;
    acc_prev_neg = 1'b0;
  endfunction

  function automatic void apply_register(input logic idx, input logic [CFG_W-1:0] value);
    if (idx == REG_FRAME_LENGTH) begin
      frame_len = value;
    end else begin
      listen_on = value[0];
      if (value[0]) clear_frame();
    end
  endfunction

  // returns 1 when the sample closes a frame
  function automatic bit accumulate_sample(input logic [SAMPLE_W-1:0] s,
                                           output features_t f);
    logic        neg;
    logic [16:0] eff;
    logic [16:0] cnt;
    logic [SQ_W-1:0] mag_sq;
    logic [WM_W-1:0] mag_wm;
    logic [WM_W-1:0] idx_wm;
    logic [SQ_W-1:0] q_energy;
    logic [31:0]     q_rate;
    f = NO_RESULT;
    if (!listen_on) return 1'b0;
    neg    = s[15];
    mag_sq = neg ? (47'h10000 - {31'b0, s}) : {31'b0, s};
    mag_wm = mag_sq[WM_W-1:0];
    idx_wm = {29'b0, acc_index};
    eff    = (frame_len == 16'd0) ? 17'd1 : {1'b0, frame_len};
    acc_square = acc_square + mag_sq * mag_sq;
    if (acc_index != '0 && neg != acc_prev_neg) acc_cross = acc_cross + 1'b1;
    if ({1'b0, acc_index} < (eff >> 1)) acc_mag = acc_mag + mag_wm * idx_wm;
    acc_prev_neg = neg;
    cnt = {1'b0, acc_index} + 17'd1;
    if (cnt < eff) begin
      acc_index = cnt[IDX_W-1:0];
      return 1'b0;
    end
    q_energy = acc_square / cnt;
    q_rate   = {acc_cross, 16'h0000} / cnt;
    f.mean_energy        = q_energy[ENERGY_W-1:0];
    f.crossing_rate      = q_rate[RATE_W-1:0];
    f.weighted_magnitude = acc_mag;
    clear_frame();
    return 1'b1;
  endfunction

  function automatic void check_field(input string label, input logic [WM_W-1:0] want,
                                      input logic [WM_W-1:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0d, got %0d", $time, label, want, got);
      mismatches++;
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample();
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(0, 3))
      0: s = 16'($urandom_range(0, 31)) - 16'd16;  // hugs zero, lots of crossings
      1: begin
        case ($urandom_range(0, 3))
          0: s = 16'h8000;
          1: s = 16'h7fff;
          2: s = 16'h0000;
          default: s = 16'hffff;
        endcase
      end
      default: s = 16'($urandom);
    endcase
    return s;
  endfunction

  function automatic logic [15:0] pick_length();
    logic [15:0] len;
    case ($urandom_range(0, 9))
      0: len = 16'($urandom_range(0, 1));
      1: len = 16'($urandom_range(25, 300));
      default: len = 16'($urandom_range(2, 24));
    endcase
    return len;
  endfunction

  always @(posedge clk) begin
    features_t got;
    features_t want;
    features_t calc;
    if (rst_n) begin
      if (cfg_we) apply_register(cfg_addr, cfg_wdata);
      if (in_tvalid && in_tready) begin
        if (accumulate_sample(in_tdata, calc))
          feature_q = {feature_q, (typed_on ? typed_result : calc)};
      end
      if (out_tvalid && out_tready) begin
        got.mean_energy        = out_tdata[30:0];
        got.crossing_rate      = out_tdata[46:31];
        got.weighted_magnitude = out_tdata[91:47];
        if (feature_q.size() == 0) begin
          $display("%0t unexpected result item: expected none, got %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = feature_q.pop_front();
          check_field("mean_energy", 45'(want.mean_energy), 45'(got.mean_energy));
          check_field("crossing_rate", 45'(want.crossing_rate), 45'(got.crossing_rate));
          check_field("weighted_magnitude", want.weighted_magnitude,
                      got.weighted_magnitude);
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (jitter_on && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t watchdog: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned gap;
    if (jitter_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_register(input logic idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, let every pending frame come out and the divider go quiet
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (feature_q.size() != 0) @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  initial begin
    step_t       plan [DIRECTED_ROWS];
    int unsigned k;
    int unsigned sent;
    int unsigned phase;
    int unsigned burst;
    int unsigned action;
    logic [SAMPLE_W-1:0] s;

    plan = '{
      // listen is off after reset, these are dropped
      '{OP_CONST,      16'h1234, 17'd3,     1'b0, NO_RESULT},
      '{OP_SET_LENGTH, 16'd1,    17'd0,     1'b0, NO_RESULT},
      '{OP_SET_LISTEN, 16'd1,    17'd0,     1'b0, NO_RESULT},
      '{OP_CONST,      16'h8000, 17'd1,     1'b1, '{31'd1073741824, 16'd0, 45'd0}},
      '{OP_CONST,      16'h7fff, 17'd1,     1'b1, '{31'd1073676289, 16'd0, 45'd0}},
      // zero length behaves as one
      '{OP_SET_LENGTH, 16'd0,    17'd0,     1'b0, NO_RESULT},
      '{OP_CONST,      16'h0000, 17'd1,     1'b1, '{31'd0, 16'd0, 45'd0}},
      '{OP_CONST,      16'hffff, 17'd1,     1'b1, '{31'd1, 16'd0, 45'd0}},
      '{OP_SET_LENGTH, 16'd2,    17'd0,     1'b0, NO_RESULT},
      '{OP_ALTERNATE,  16'h7fff, 17'd2,     1'b1, '{31'd1073709056, 16'd32768, 45'd0}},
      '{OP_SET_LENGTH, 16'd4,    17'd0,     1'b0, NO_RESULT},
      '{OP_ALTERNATE,  16'h0001, 17'd4,     1'b1, '{31'd2, 16'd49152, 45'd2}},
      '{OP_SET_LENGTH, 16'd40,   17'd0,     1'b0, NO_RESULT},
      '{OP_ALTERNATE,  16'h8000, 17'd40,    1'b0, NO_RESULT},
      // shrink the length with five samples already held
      '{OP_SET_LENGTH, 16'd9,    17'd0,     1'b0, NO_RESULT},
      '{OP_RANDOM,     16'h0000, 17'd5,     1'b0, NO_RESULT},
      '{OP_SET_LENGTH, 16'd3,    17'd0,     1'b0, NO_RESULT},
      '{OP_RANDOM,     16'h0000, 17'd1,     1'b0, NO_RESULT},
      '{OP_RANDOM,     16'h0000, 17'd5,     1'b0, NO_RESULT},
      // partial frame dropped by disable and re-enable
      '{OP_SET_LISTEN, 16'd0,    17'd0,     1'b0, NO_RESULT},
      '{OP_RANDOM,     16'h0000, 17'd4,     1'b0, NO_RESULT},
      '{OP_SET_LISTEN, 16'd1,    17'd0,     1'b0, NO_RESULT},
      '{OP_RANDOM,     16'h0000, 17'd3,     1'b0, NO_RESULT},
      // longest length, the held frame closes once the length drops again
      '{OP_SET_LENGTH, 16'hffff, 17'd0,     1'b0, NO_RESULT},
      '{OP_CONST,      16'h8000, 17'd20,    1'b0, NO_RESULT}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      case (plan[i].op)
        OP_SET_LENGTH: write_register(REG_FRAME_LENGTH, plan[i].value);
        OP_SET_LISTEN: write_register(REG_LISTEN_ENABLE, plan[i].value);
        default: begin
          typed_on     = plan[i].typed;
          typed_result = plan[i].known;
          for (k = 0; k < plan[i].count; k++) begin
            case (plan[i].op)
              OP_CONST:     s = plan[i].value;
              OP_ALTERNATE: s = k[0] ? ~plan[i].value : plan[i].value;
              default:      s = draw_sample();
            endcase
            push_sample(s);
          end
          drain_results();
          typed_on = 1'b0;
        end
      endcase
    end

    write_register(REG_FRAME_LENGTH, 16'd8);
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      // no jitter in the last quarter, and every fourth phase runs clean
      jitter_on = (sent < RANDOM_ITEMS * 3 / 4) && (phase % 4 != 3);
      action = $urandom_range(0, 9);
      if (action < 5) begin
        drain_results();
        write_register(REG_FRAME_LENGTH, pick_length());
        // without the enable write the held partial frame carries over
        if ($urandom_range(0, 1) == 1) write_register(REG_LISTEN_ENABLE, 16'd1);
      end else if (action == 5) begin
        drain_results();
        write_register(REG_LISTEN_ENABLE, 16'd0);
        repeat ($urandom_range(1, 6)) push_sample(draw_sample());
        drain_results();
        write_register(REG_LISTEN_ENABLE, 16'd1);
      end else if (action == 6) begin
        drain_results();
      end
      burst = $urandom_range(4, 40);
      repeat (burst) push_sample(draw_sample());
      sent  += burst;
      phase++;
    end

    drain_results();
    if (mismatches == 0 && feature_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[files.f]
sv/fez_pkg.sv
sv/fez_accum.sv
sv/fez_div.sv
sv/fez_ctrl.sv
sv/frame_energy_zcr_extractor.sv
dv/tb.sv
